// ===== hw/rtl/pcs_pkg.sv =====
// Shared types and constants of the piecewise contrast stretch core.
`timescale 1ns / 1ps

package pcs_pkg;

    localparam int unsigned PIX_W    = 8;
    localparam int unsigned PROD_W   = 2 * PIX_W;
    localparam int unsigned DIV_BITS = 4;              // quotient bits per divider stage
    localparam int unsigned DIV_STGS = PROD_W / DIV_BITS;
    localparam int unsigned ADDR_W   = 4;
    localparam int unsigned DATA_W   = 32;

    localparam logic [PIX_W-1:0] MAX_LEVEL = 8'd255;

    localparam logic [1:0] REG_LOW_IN   = 2'd0;
    localparam logic [1:0] REG_LOW_OUT  = 2'd1;
    localparam logic [1:0] REG_HIGH_IN  = 2'd2;
    localparam logic [1:0] REG_HIGH_OUT = 2'd3;

    localparam logic [PIX_W-1:0] RST_LOW_IN   = 8'd70;
    localparam logic [PIX_W-1:0] RST_LOW_OUT  = 8'd0;
    localparam logic [PIX_W-1:0] RST_HIGH_IN  = 8'd140;
    localparam logic [PIX_W-1:0] RST_HIGH_OUT = 8'd255;

    typedef struct packed {
        logic [PIX_W-1:0] low_break_in;
        logic [PIX_W-1:0] low_break_out;
        logic [PIX_W-1:0] high_break_in;
        logic [PIX_W-1:0] high_break_out;
    } t_cfg;

    // Payload of one beat in the divider chain. acc holds the remaining
    // dividend bits in its upper part and the quotient bits shifted in below.
    typedef struct packed {
        logic              neg;
        logic [PIX_W-1:0]  base;
        logic [PIX_W-1:0]  span;
        logic [PIX_W-1:0]  rem;
        logic [PROD_W-1:0] acc;
    } t_div_beat;

endpackage

// ===== hw/rtl/pcs_regs.sv =====
// Configuration register bank of the contrast stretch core, APB-style access.
`timescale 1ns / 1ps

module pcs_regs import pcs_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    t_cfg             r_cfg;
    logic [1:0]       reg_idx;
    logic [PIX_W-1:0] rd_val;

    assign pready  = 1'b1;
    assign reg_idx = paddr[ADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.low_break_in   <= RST_LOW_IN;
            r_cfg.low_break_out  <= RST_LOW_OUT;
            r_cfg.high_break_in  <= RST_HIGH_IN;
            r_cfg.high_break_out <= RST_HIGH_OUT;
        end else if (psel && penable && pwrite) begin
            unique case (reg_idx)
                REG_LOW_IN:   r_cfg.low_break_in   <= pwdata[PIX_W-1:0];
                REG_LOW_OUT:  r_cfg.low_break_out  <= pwdata[PIX_W-1:0];
                REG_HIGH_IN:  r_cfg.high_break_in  <= pwdata[PIX_W-1:0];
                REG_HIGH_OUT: r_cfg.high_break_out <= pwdata[PIX_W-1:0];
                default:      ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_LOW_IN:   rd_val = r_cfg.low_break_in;
            REG_LOW_OUT:  rd_val = r_cfg.low_break_out;
            REG_HIGH_IN:  rd_val = r_cfg.high_break_in;
            REG_HIGH_OUT: rd_val = r_cfg.high_break_out;
            default:      rd_val = '0;
        endcase
    end

    assign prdata = {{(DATA_W-PIX_W){1'b0}}, rd_val};
    assign o_cfg  = r_cfg;

endmodule

// ===== hw/rtl/pcs_seg.sv =====
// Segment selection and slope multiply: two register stages feeding the divider.
`timescale 1ns / 1ps

module pcs_seg import pcs_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cfg             i_cfg,
    input  logic             i_valid,
    input  logic [PIX_W-1:0] i_pixel,
    output logic             o_valid,
    output t_div_beat        o_beat
);

    typedef struct packed {
        logic             neg;
        logic [PIX_W-1:0] mag;
        logic [PIX_W-1:0] base;
        logic [PIX_W-1:0] offset;
        logic [PIX_W-1:0] span;
    } t_seg_beat;

    t_seg_beat        n_seg;
    t_seg_beat        r_seg;
    logic             r_seg_valid;
    t_div_beat        n_beat;
    t_div_beat        r_beat;
    logic             r_valid;
    logic [PIX_W-1:0] out1;
    logic [PIX_W:0]   diff;

    // Pick the segment; a zero first breakpoint gives a flat span of one.
    always_comb begin
        if (i_pixel <= i_cfg.low_break_in) begin
            n_seg.base   = '0;
            out1         = (i_cfg.low_break_in == '0) ? '0 : i_cfg.low_break_out;
            n_seg.offset = i_pixel;
            n_seg.span   = (i_cfg.low_break_in == '0) ? PIX_W'(1) : i_cfg.low_break_in;
        end else if (i_pixel <= i_cfg.high_break_in) begin
            n_seg.base   = i_cfg.low_break_out;
            out1         = i_cfg.high_break_out;
            n_seg.offset = i_pixel - i_cfg.low_break_in;
            n_seg.span   = i_cfg.high_break_in - i_cfg.low_break_in;
        end else begin
            n_seg.base   = i_cfg.high_break_out;
            out1         = MAX_LEVEL;
            n_seg.offset = i_pixel - i_cfg.high_break_in;
            n_seg.span   = MAX_LEVEL - i_cfg.high_break_in;
        end
        diff      = {1'b0, out1} - {1'b0, n_seg.base};
        n_seg.neg = diff[PIX_W];
        n_seg.mag = diff[PIX_W] ? PIX_W'(-diff) : diff[PIX_W-1:0];
    end

    always_comb begin
        n_beat.neg  = r_seg.neg;
        n_beat.base = r_seg.base;
        n_beat.span = r_seg.span;
        n_beat.rem  = '0;
        n_beat.acc  = r_seg.mag * r_seg.offset;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seg_valid <= 1'b0;
            r_valid     <= 1'b0;
        end else begin
            r_seg_valid <= i_valid;
            r_valid     <= r_seg_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_seg  <= n_seg;
        r_beat <= n_beat;
    end

    assign o_valid = r_valid;
    assign o_beat  = r_beat;

endmodule

// ===== hw/rtl/pcs_div_stage.sv =====
// One stage of the pipelined restoring divider: a few quotient bits per beat.
`timescale 1ns / 1ps

module pcs_div_stage import pcs_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    input  t_div_beat i_beat,
    output logic      o_valid,
    output t_div_beat o_beat
);

    t_div_beat n_beat;
    t_div_beat r_beat;
    logic      r_valid;

    always_comb begin
        logic [PIX_W:0] trial;
        n_beat = i_beat;
        for (int k = 0; k < DIV_BITS; k++) begin
            trial      = {n_beat.rem, n_beat.acc[PROD_W-1]};
            n_beat.acc = {n_beat.acc[PROD_W-2:0], 1'b0};
            if (trial >= {1'b0, n_beat.span}) begin
                trial         = trial - {1'b0, n_beat.span};
                n_beat.acc[0] = 1'b1;
            end
            n_beat.rem = trial[PIX_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_beat <= n_beat;
    end

    assign o_valid = r_valid;
    assign o_beat  = r_beat;

endmodule

// ===== hw/rtl/piecewise_contrast_stretch_core.sv =====
// Top level of the piecewise linear contrast stretch core.
`timescale 1ns / 1ps

// Remap each 8-bit grey level through a three-segment linear curve set by two
// breakpoints held in APB registers. The core takes one pixel per clock: busy
// is never raised, so start may be held high on every cycle. Each pixel comes
// back on o_pixel_out with o_valid high for one cycle, in the order taken,
// after passing through the pipeline: segment select, one slope multiply, four
// divider stages of four quotient bits each, and a final stage that adds the
// segment base and clamps to 0..255. The receiver cannot stall the core and
// must take every beat as it appears. Write the registers only while no pixel
// is in flight.
module piecewise_contrast_stretch_core import pcs_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // pixel stream
    input  logic              start,
    output logic              busy,
    input  logic [PIX_W-1:0]  i_pixel_in,
    output logic              o_valid,
    output logic [PIX_W-1:0]  o_pixel_out,
    // register port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    t_cfg             cfg;
    logic             accept;
    logic             chain_valid [DIV_STGS+1];
    t_div_beat        chain_beat  [DIV_STGS+1];
    t_div_beat        last_beat;
    logic [PIX_W:0]   sum;
    logic [PIX_W-1:0] n_pixel;
    logic [PIX_W-1:0] r_pixel;
    logic             r_valid;

    // Fully pipelined: never hold off the source.
    assign busy   = 1'b0;
    assign accept = start && !busy;

    pcs_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Select the segment, then form |slope numerator| * offset.
    pcs_seg u_seg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_valid (accept),
        .i_pixel (i_pixel_in),
        .o_valid (chain_valid[0]),
        .o_beat  (chain_beat[0])
    );

    // Divide the product magnitude by the segment span, a few bits a stage.
    for (genvar g = 0; g < DIV_STGS; g++) begin : g_div
        pcs_div_stage u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (chain_valid[g]),
            .i_beat  (chain_beat[g]),
            .o_valid (chain_valid[g+1]),
            .o_beat  (chain_beat[g+1])
        );
    end

    assign last_beat = chain_beat[DIV_STGS];

    // Apply the sign of the slope to the truncated quotient, add the base
    // and clamp. A falling segment clamps at zero, a rising one at full scale.
    always_comb begin
        sum = '0;
        if (last_beat.neg) begin
            if (last_beat.acc > PROD_W'(last_beat.base)) begin
                n_pixel = '0;
            end else begin
                n_pixel = last_beat.base - last_beat.acc[PIX_W-1:0];
            end
        end else if (last_beat.acc[PROD_W-1:PIX_W] != '0) begin
            n_pixel = MAX_LEVEL;
        end else begin
            sum     = {1'b0, last_beat.base} + {1'b0, last_beat.acc[PIX_W-1:0]};
            n_pixel = sum[PIX_W] ? MAX_LEVEL : sum[PIX_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= chain_valid[DIV_STGS];
        end
    end

    always_ff @(posedge i_clk) begin
        r_pixel <= n_pixel;
    end

    assign o_valid     = r_valid;
    assign o_pixel_out = r_pixel;

endmodule
